### sv/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

  // full scale of the hue, saturation and lightness inputs
  localparam logic [7:0] FULL_SCALE = 8'd240;
  // lightness at or below this takes the l*(1+s) branch
  localparam logic [7:0] HALF_SCALE = 8'd120;
  // v at full scale, in units of 1/57600
  localparam logic [15:0] V_FULL = 16'd57600;

  // width of a channel value scaled by 2304000
  localparam int unsigned CHAN_W = 22;
  // width of the channel value after the divide by 2048
  localparam int unsigned QUOT_W = 15;
  // reciprocal of 75 for the final divide, shifted by RECIP_SHIFT
  localparam logic [15:0] RECIP_75 = 16'd55925;
  localparam int unsigned RECIP_SHIFT = 22;

  // hue sextant, grey when hue is at full scale
  typedef enum logic [2:0] {
    SEXT_0,
    SEXT_1,
    SEXT_2,
    SEXT_3,
    SEXT_4,
    SEXT_5,
    SEXT_GREY
  } sextant_t;

  // stage enables handed to the channel scaler
  typedef struct packed {
    logic mul;
    logic out;
  } scale_en_t;

endpackage

`default_nettype wire

### sv/hsl_if.sv
`default_nettype none

interface hsl_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                output ready);
endinterface

`default_nettype wire

### sv/rgb_if.sv
`default_nettype none

interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### sv/hsl_scale.sv
`default_nettype none

// floor(x*255/2304000) = floor(floor(x*17/2048)/75), two register stages
module hsl_scale (
  input  wire logic                          clk,
  input  wire hsl_pkg::scale_en_t            en,
  input  wire logic [hsl_pkg::CHAN_W-1:0]    x,
  output logic [7:0]                         chan
);

  logic [hsl_pkg::CHAN_W+3:0]  prod17;
  logic [hsl_pkg::QUOT_W-1:0]  quot;
  logic [30:0]                 recip_prod;

  // times 17, then drop the low eleven bits
  assign prod17 = {x, 4'd0} + {4'd0, x};

  always_ff @(posedge clk) begin
    if (en.mul) begin
      quot <= prod17[hsl_pkg::CHAN_W+3:11];
    end
  end

  // divide by 75 through the reciprocal, exact for quotients up to 19125
  assign recip_prod = {16'd0, quot} * {15'd0, hsl_pkg::RECIP_75};

  always_ff @(posedge clk) begin
    if (en.out) begin
      chan <= recip_prod[hsl_pkg::RECIP_SHIFT+7:hsl_pkg::RECIP_SHIFT];
    end
  end

endmodule

`default_nettype wire

### sv/hsl_to_rgb_pixel.sv
`default_nettype none

// HSL to RGB pixel converter. Hue, saturation and lightness arrive on a
// 0..240 scale (values above 240 saturate to 240, hue 240 gives grey) and
// leave as 8-bit red, green and blue, each exactly floor(channel*255).
// One pixel enters per clock while the output drains, through six register
// stages (clamp and product, v and m, offset, sextant routing, times 17,
// divide by 75), each with its own valid bit. A stage holds while the one
// after it is full and stalled, so gaps close up under back-pressure and
// the input stays ready until all six stages are full.
module hsl_to_rgb_pixel (
  input  wire logic clk,
  input  wire logic rst,
  hsl_if.sink       hsl,
  rgb_if.source     rgb
);

  localparam int unsigned NSTAGE = 6;

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] en;

  // stage A
  logic [7:0]          hv_c;
  logic [7:0]          sv_c;
  logic [7:0]          lv_c;
  hsl_pkg::sextant_t   sext_in;
  logic [7:0]          sext_base;
  logic [7:0]          hue_rem;
  logic                lv_high;
  logic [7:0]          mul_a;
  logic [8:0]          mul_b;
  logic [16:0]         mul_p;
  logic [15:0]         a_prod;
  logic                a_high;
  logic [7:0]          a_lv;
  hsl_pkg::sextant_t   a_sext;
  logic [5:0]          a_frac;

  // stage B
  logic [15:0]         vq;
  logic [16:0]         l480;
  logic [16:0]         mq_wide;
  logic [15:0]         b_vq;
  logic [15:0]         b_mq;
  logic [7:0]          b_lv;
  hsl_pkg::sextant_t   b_sext;
  logic [5:0]          b_frac;

  // stage C
  logic [15:0]                  diff;
  logic [21:0]                  off_p;
  logic [hsl_pkg::CHAN_W-1:0]   c_vs;
  logic [hsl_pkg::CHAN_W-1:0]   c_ms;
  logic [hsl_pkg::CHAN_W-1:0]   c_off;
  logic [hsl_pkg::CHAN_W-1:0]   c_grey;
  hsl_pkg::sextant_t            c_sext;
  logic                         c_black;

  // stage D
  logic [hsl_pkg::CHAN_W-1:0]   up;
  logic [hsl_pkg::CHAN_W-1:0]   down;
  logic [hsl_pkg::CHAN_W-1:0]   r_sel;
  logic [hsl_pkg::CHAN_W-1:0]   g_sel;
  logic [hsl_pkg::CHAN_W-1:0]   b_sel;
  logic [hsl_pkg::CHAN_W-1:0]   d_r;
  logic [hsl_pkg::CHAN_W-1:0]   d_g;
  logic [hsl_pkg::CHAN_W-1:0]   d_b;

  hsl_pkg::scale_en_t           scale_en;

  // per-stage advance: a stage loads when empty or when it drains itself
  always_comb begin
    en[NSTAGE-1] = !valid[NSTAGE-1] || rgb.ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign hsl.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= hsl.valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  // input clamp
  assign hv_c = (hsl.hue > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE : hsl.hue;
  assign sv_c = (hsl.saturation > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE
                                                       : hsl.saturation;
  assign lv_c = (hsl.lightness > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE
                                                      : hsl.lightness;

  // hue sextant and position inside it
  always_comb begin
    if (hv_c >= 8'd240) begin
      sext_in = hsl_pkg::SEXT_GREY; sext_base = 8'd240;
    end else if (hv_c >= 8'd200) begin
      sext_in = hsl_pkg::SEXT_5; sext_base = 8'd200;
    end else if (hv_c >= 8'd160) begin
      sext_in = hsl_pkg::SEXT_4; sext_base = 8'd160;
    end else if (hv_c >= 8'd120) begin
      sext_in = hsl_pkg::SEXT_3; sext_base = 8'd120;
    end else if (hv_c >= 8'd80) begin
      sext_in = hsl_pkg::SEXT_2; sext_base = 8'd80;
    end else if (hv_c >= 8'd40) begin
      sext_in = hsl_pkg::SEXT_1; sext_base = 8'd40;
    end else begin
      sext_in = hsl_pkg::SEXT_0; sext_base = 8'd0;
    end
  end

  assign hue_rem = hv_c - sext_base;

  // one multiplier: l*(240+s) for dark pixels, (240-l)*(240-s) for light
  assign lv_high = lv_c > hsl_pkg::HALF_SCALE;
  assign mul_a   = lv_high ? (hsl_pkg::FULL_SCALE - lv_c) : lv_c;
  assign mul_b   = lv_high ? {1'b0, hsl_pkg::FULL_SCALE - sv_c}
                           : ({1'b0, hsl_pkg::FULL_SCALE} + {1'b0, sv_c});
  assign mul_p   = {9'd0, mul_a} * {8'd0, mul_b};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_prod <= mul_p[15:0];
      a_high <= lv_high;
      a_lv   <= lv_c;
      a_sext <= sext_in;
      a_frac <= hue_rem[5:0];
    end
  end

  // v and m in units of 1/57600
  assign vq      = a_high ? (hsl_pkg::V_FULL - a_prod) : a_prod;
  assign l480    = {a_lv, 9'd0} - {4'd0, a_lv, 5'd0};
  assign mq_wide = l480 - {1'b0, vq};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_vq   <= vq;
      b_mq   <= mq_wide[15:0];
      b_lv   <= a_lv;
      b_sext <= a_sext;
      b_frac <= a_frac;
    end
  end

  // offset (v-m)*frac, and v, m, grey scaled to units of 1/2304000
  assign diff  = b_vq - b_mq;
  assign off_p = {6'd0, diff} * {16'd0, b_frac};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_vs    <= {1'b0, b_vq, 5'd0} + {3'd0, b_vq, 3'd0};
      c_ms    <= {1'b0, b_mq, 5'd0} + {3'd0, b_mq, 3'd0};
      c_off   <= off_p;
      c_grey  <= {14'd0, b_lv} * 22'd9600;
      c_sext  <= b_sext;
      c_black <= (b_vq == 16'd0);
    end
  end

  // sextant routing
  assign up   = c_ms + c_off;
  assign down = c_vs - c_off;

  always_comb begin
    r_sel = c_grey;
    g_sel = c_grey;
    b_sel = c_grey;
    if (!c_black) begin
      case (c_sext)
        hsl_pkg::SEXT_0: begin r_sel = c_vs; g_sel = up;   b_sel = c_ms; end
        hsl_pkg::SEXT_1: begin r_sel = down; g_sel = c_vs; b_sel = c_ms; end
        hsl_pkg::SEXT_2: begin r_sel = c_ms; g_sel = c_vs; b_sel = up;   end
        hsl_pkg::SEXT_3: begin r_sel = c_ms; g_sel = down; b_sel = c_vs; end
        hsl_pkg::SEXT_4: begin r_sel = up;   g_sel = c_ms; b_sel = c_vs; end
        hsl_pkg::SEXT_5: begin r_sel = c_vs; g_sel = c_ms; b_sel = down; end
        default: begin r_sel = c_grey; g_sel = c_grey; b_sel = c_grey; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_r <= r_sel;
      d_g <= g_sel;
      d_b <= b_sel;
    end
  end

  // scale each channel to 0..255
  assign scale_en.mul = en[4];
  assign scale_en.out = en[5];

  hsl_scale u_scale_r (.clk(clk), .en(scale_en), .x(d_r), .chan(rgb.red));
  hsl_scale u_scale_g (.clk(clk), .en(scale_en), .x(d_g), .chan(rgb.green));
  hsl_scale u_scale_b (.clk(clk), .en(scale_en), .x(d_b), .chan(rgb.blue));

  assign rgb.valid = valid[NSTAGE-1];

endmodule

`default_nettype wire

### sv/hsl_chk.sv
`default_nettype none

module hsl_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  logic in_req;
  assign in_req = in_valid && in_ready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // with the output draining and no reset, an accepted request reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_req, 6) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
      && !$past(rst, 4) && !$past(rst, 5) && !$past(rst, 6)
      && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
      && $past(out_ready, 4) && $past(out_ready, 5)
      |-> out_valid)
    else $error("request missing at the output after six cycles");

endmodule

bind hsl_to_rgb_pixel hsl_chk u_hsl_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (hsl.valid),
  .in_ready (hsl.ready),
  .out_valid(rgb.valid),
  .out_ready(rgb.ready),
  .red      (rgb.red),
  .green    (rgb.green),
  .blue     (rgb.blue)
);

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;

  // one rgb pixel as the converter should deliver it
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // predicts each pixel and matches the converter output in order
  class pixel_scoreboard;
    rgb_pixel_t  pixel_q[$];
    int unsigned fail_count;

    // exact hsl to rgb conversion, channel values scaled by 2304000
    function automatic rgb_pixel_t hsl_to_rgb(input logic [7:0] h, s, l);
      int unsigned        hv, sv, lv, grey, vq, mq, vs, ms, offset, up, down;
      int unsigned        chan [3];
      hsl_pkg::sextant_t  sext;
      rgb_pixel_t         px;
      hv = (h > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE : h;
      sv = (s > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE : s;
      lv = (l > hsl_pkg::FULL_SCALE) ? hsl_pkg::FULL_SCALE : l;
      grey = lv * 9600;
      chan = '{grey, grey, grey};
      // v and m in units of 1/57600
      if (lv <= hsl_pkg::HALF_SCALE) begin
        vq = lv * (240 + sv);
      end else begin
        vq = 240 * lv + 240 * sv - lv * sv;
      end
      mq = 480 * lv - vq;
      sext = hsl_pkg::sextant_t'(hv / 40);
      if (vq != 0) begin
        vs = vq * 40;
        ms = mq * 40;
        offset = (vq - mq) * (hv % 40);
        up = ms + offset;
        down = vs - offset;
        case (sext)
          hsl_pkg::SEXT_0: chan = '{vs, up, ms};
          hsl_pkg::SEXT_1: chan = '{down, vs, ms};
          hsl_pkg::SEXT_2: chan = '{ms, vs, up};
          hsl_pkg::SEXT_3: chan = '{ms, down, vs};
          hsl_pkg::SEXT_4: chan = '{up, ms, vs};
          hsl_pkg::SEXT_5: chan = '{vs, ms, down};
          default: ;
        endcase
      end
      px.red   = 8'((longint'(chan[0]) * 255) / 2304000);
      px.green = 8'((longint'(chan[1]) * 255) / 2304000);
      px.blue  = 8'((longint'(chan[2]) * 255) / 2304000);
      return px;
    endfunction

    function void note_request(input logic [7:0] h, s, l);
      pixel_q.push_back(hsl_to_rgb(h, s, l));
    endfunction

    function void check_result(input logic [7:0] r, g, b);
      rgb_pixel_t want;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, r, g, b);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (want.red !== r || want.green !== g || want.blue !== b) begin
          $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue, r, g, b);
          fail_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;
  logic src_idle_on;

  hsl_if hsl_bus ();
  rgb_if rgb_bus ();

  pixel_scoreboard sb = new;

  hsl_to_rgb_pixel u_top (
    .clk (clk),
    .rst (rst),
    .hsl (hsl_bus),
    .rgb (rgb_bus)
  );

  // clock
  always #2 clk = ~clk;

  // random 0..240 mostly, with the occasional out-of-range value
  function automatic logic [7:0] rand_field();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(241, 255));
    end
    return 8'($urandom_range(0, 240));
  endfunction

  // present one request and hold it until accepted
  task automatic send_pixel(input logic [7:0] h, s, l);
    hsl_bus.valid      <= 1'b1;
    hsl_bus.hue        <= h;
    hsl_bus.saturation <= s;
    hsl_bus.lightness  <= l;
    @(posedge clk);
    while (!hsl_bus.ready) @(posedge clk);
    sb.note_request(h, s, l);
    if (!calm && src_idle_on && $urandom_range(0, 2) == 0) begin
      hsl_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // output back-pressure in bursts
  initial begin
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        rgb_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rgb_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && rgb_bus.valid && rgb_bus.ready) begin
      sb.check_result(rgb_bus.red, rgb_bus.green, rgb_bus.blue);
    end
  end

  // run limit
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    calm <= 1'b0;
    src_idle_on <= 1'b1;
    hsl_bus.valid      <= 1'b0;
    hsl_bus.hue        <= 8'd0;
    hsl_bus.saturation <= 8'd0;
    hsl_bus.lightness  <= 8'd0;
    rgb_bus.ready      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // black, primaries at every sextant edge, grey hue, clamping, branch edges
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd240, 8'd0);
    send_pixel(8'd0, 8'd240, 8'd120);
    send_pixel(8'd40, 8'd240, 8'd120);
    send_pixel(8'd80, 8'd240, 8'd120);
    send_pixel(8'd120, 8'd240, 8'd120);
    send_pixel(8'd160, 8'd240, 8'd120);
    send_pixel(8'd200, 8'd240, 8'd120);
    send_pixel(8'd39, 8'd240, 8'd120);
    send_pixel(8'd239, 8'd240, 8'd120);
    send_pixel(8'd240, 8'd240, 8'd120);
    send_pixel(8'd241, 8'd100, 8'd100);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd20, 8'd255, 8'd60);
    send_pixel(8'd100, 8'd180, 8'd250);
    send_pixel(8'd60, 8'd0, 8'd180);
    send_pixel(8'd10, 8'd240, 8'd240);
    send_pixel(8'd130, 8'd200, 8'd121);
    send_pixel(8'd130, 8'd200, 8'd120);
    send_pixel(8'd170, 8'd1, 8'd1);
    send_pixel(8'd225, 8'd170, 8'd230);
    send_pixel(8'd0, 8'd128, 8'd127);
    send_pixel(8'd127, 8'd85, 8'd42);

    // random pixels, idle-free stretches now and then, none at the end
    for (int i = 0; i < 600; i++) begin
      if (i % 50 == 0) src_idle_on <= ($urandom_range(0, 3) != 0);
      if (i == 500) calm <= 1'b1;
      send_pixel(rand_field(), rand_field(), rand_field());
    end
    hsl_bus.valid <= 1'b0;

    // drain, the output is held ready once calm
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
